// ----- rtl/bmhq_pkg.sv -----
// Shared definitions for the binary min-heap queue: default sizes, opcodes,
// status codes and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package bmhq_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int KEY_W_DEF = 31;
  localparam int TAG_W_DEF = 16;

  // Capacity register is a fixed-width field.
  localparam int          CAP_W     = 7;
  localparam logic [6:0]  CAP_RESET = 7'd64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Controller to datapath.
  typedef struct packed {
    logic    ins_start;    // latch new entry, pos <= count, count++
    logic    rem_start;    // read root and last entry, count--
    logic    ld_root;      // capture root as result, last entry as mover
    logic    rd_parent;    // read parent of pos
    logic    rd_children;  // read both children of pos
    logic    step_up;      // write parent at pos, move pos to parent
    logic    step_down;    // write chosen child at pos, move pos to child
    logic    place;        // write mover at pos
    logic    done;         // emit a result beat
    logic    done_entry;   // result carries the removed entry
    status_t done_status;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic at_root;
    logic leaf;
    logic parent_less;
    logic child_greater;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/bmhq_ctrl.sv -----
// Controller for the binary min-heap queue: sequences insert sift-up and
// remove sift-down over the datapath. Depends on bmhq_pkg.
`default_nettype none

module bmhq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            opcode,
  input  wire bmhq_pkg::stat_t stat,
  output bmhq_pkg::cmd_t       cmd,
  output logic                 busy
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_UP_RD  = 6'b000010,
    S_UP_CMP = 6'b000100,
    S_DN_LD  = 6'b001000,
    S_DN_RD  = 6'b010000,
    S_DN_CMP = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == bmhq_pkg::OP_INSERT) begin
            if (stat.full) begin
              cmd.done        = 1'b1;
              cmd.done_status = bmhq_pkg::ST_FULL;
            end else begin
              cmd.ins_start = 1'b1;
              state_next    = S_UP_RD;
            end
          end else begin
            if (stat.empty) begin
              cmd.done        = 1'b1;
              cmd.done_status = bmhq_pkg::ST_EMPTY;
            end else begin
              cmd.rem_start = 1'b1;
              state_next    = S_DN_LD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (stat.at_root) begin
          cmd.place  = 1'b1;
          cmd.done   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_parent = 1'b1;
          state_next    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        // equal keys keep rising
        if (stat.parent_less) begin
          cmd.place  = 1'b1;
          cmd.done   = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.step_up = 1'b1;
          state_next  = S_UP_RD;
        end
      end
      S_DN_LD: begin
        cmd.ld_root = 1'b1;
        state_next  = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat.leaf) begin
          cmd.place      = 1'b1;
          cmd.done       = 1'b1;
          cmd.done_entry = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_children = 1'b1;
          state_next      = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat.child_greater) begin
          cmd.place      = 1'b1;
          cmd.done       = 1'b1;
          cmd.done_entry = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.step_down = 1'b1;
          state_next    = S_DN_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.done |=> !busy)
    else $error("controller not idle after result beat");

  a_rem_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.rem_start |=> (state == S_DN_LD))
    else $error("remove did not enter root load");

endmodule

`default_nettype wire

// ----- rtl/bmhq_dp.sv -----
// Datapath for the binary min-heap queue: heap memory with two read ports,
// count and capacity registers, sift position, mover and result registers.
// Depends on bmhq_pkg.
`default_nettype none

module bmhq_dp #(
  parameter int DEPTH = bmhq_pkg::DEPTH_DEF,
  parameter int KEY_W = bmhq_pkg::KEY_W_DEF,
  parameter int TAG_W = bmhq_pkg::TAG_W_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [KEY_W-1:0]           key,
  input  wire logic [TAG_W-1:0]           tag,
  input  wire logic                       cfg_we,
  input  wire logic [bmhq_pkg::CAP_W-1:0] cfg_wdata,
  input  wire bmhq_pkg::cmd_t             cmd,
  output bmhq_pkg::stat_t                 stat,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [KEY_W-1:0]                out_key,
  output logic [TAG_W-1:0]                out_tag,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CHW   = IDX_W + 2;
  localparam int CW    = (CNT_W > bmhq_pkg::CAP_W) ? CNT_W : bmhq_pkg::CAP_W;
  localparam int ENT_W = KEY_W + TAG_W;

  logic [ENT_W-1:0] mem [DEPTH];

  logic [ENT_W-1:0]           rdata_a;
  logic [ENT_W-1:0]           rdata_b;
  logic [CNT_W-1:0]           cnt;
  logic [bmhq_pkg::CAP_W-1:0] cap;
  logic [IDX_W-1:0]           pos;
  logic [KEY_W-1:0]           mov_key;
  logic [TAG_W-1:0]           mov_tag;
  logic [KEY_W-1:0]           root_key;
  logic [TAG_W-1:0]           root_tag;
  bmhq_pkg::status_t          res_status;

  logic [IDX_W-1:0] parent;
  logic [CHW-1:0]   child_l;
  logic [CHW-1:0]   child_r;
  logic [CHW-1:0]   cnt_w;
  logic             right_ok;
  logic [IDX_W-1:0] chosen;
  logic [ENT_W-1:0] chosen_ent;
  logic [IDX_W-1:0] rd_a_addr;
  logic [IDX_W-1:0] rd_b_addr;
  logic             rd_en;
  logic             we;
  logic [ENT_W-1:0] wdata;
  logic [KEY_W-1:0] key_a;
  logic [KEY_W-1:0] key_b;

  assign key_a   = rdata_a[ENT_W-1:TAG_W];
  assign key_b   = rdata_b[ENT_W-1:TAG_W];
  assign parent  = IDX_W'((pos - 1'b1) >> 1);
  assign child_l = CHW'({pos, 1'b1});
  assign child_r = child_l + CHW'(1);
  assign cnt_w   = CHW'(cnt);

  // right child wins ties, and only when it lies below the count
  assign right_ok   = (child_r < cnt_w) && (key_b <= key_a);
  assign chosen     = right_ok ? child_r[IDX_W-1:0] : child_l[IDX_W-1:0];
  assign chosen_ent = right_ok ? rdata_b : rdata_a;

  assign rd_en     = cmd.rem_start | cmd.rd_parent | cmd.rd_children;
  assign rd_a_addr = cmd.rem_start ? '0 : (cmd.rd_parent ? parent : child_l[IDX_W-1:0]);
  assign rd_b_addr = cmd.rem_start ? IDX_W'(cnt - 1'b1) : child_r[IDX_W-1:0];

  assign we    = cmd.place | cmd.step_up | cmd.step_down;
  assign wdata = cmd.place   ? {mov_key, mov_tag} :
                 cmd.step_up ? rdata_a : chosen_ent;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[pos] <= wdata;
    end
    if (rd_en) begin
      rdata_a <= mem[rd_a_addr];
      rdata_b <= mem[rd_b_addr];
    end
  end

  assign stat.full          = (CW'(cnt) >= CW'(cap)) || (CW'(cnt) >= CW'(DEPTH));
  assign stat.empty         = (cnt == '0);
  assign stat.at_root       = (pos == '0);
  assign stat.leaf          = (child_l >= cnt_w);
  assign stat.parent_less   = (key_a < mov_key);
  assign stat.child_greater = (chosen_ent[ENT_W-1:TAG_W] > mov_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      cap <= bmhq_pkg::CAP_RESET;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (cmd.ins_start) begin
        cnt <= cnt + CNT_W'(1);
      end else if (cmd.rem_start) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_start) begin
      mov_key <= key;
      mov_tag <= tag;
      pos     <= IDX_W'(cnt);
    end else if (cmd.rem_start) begin
      pos <= '0;
    end else if (cmd.ld_root) begin
      root_key <= key_a;
      root_tag <= rdata_a[TAG_W-1:0];
      mov_key  <= key_b;
      mov_tag  <= rdata_b[TAG_W-1:0];
    end else if (cmd.step_up) begin
      pos <= parent;
    end else if (cmd.step_down) begin
      pos <= chosen;
    end
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.done;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done) begin
      res_status <= cmd.done_status;
      out_key    <= cmd.done_entry ? root_key : '0;
      out_tag    <= cmd.done_entry ? root_tag : '0;
      count      <= cnt;
    end
  end

  assign status = res_status;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    CW'(cnt) <= CW'(DEPTH))
    else $error("entry count above depth");

  // the last remove leaves the heap empty and drops its mover at the root
  a_write_live: assert property (@(posedge clk) disable iff (rst)
    we |-> ((CHW'(pos) < cnt_w) || stat.empty))
    else $error("heap write outside live entries");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_start |=> (cnt == $past(cnt) + CNT_W'(1)))
    else $error("insert did not bump count");

endmodule

`default_nettype wire

// ----- rtl/binary_min_heap_queue_core.sv -----
// Binary min-heap priority queue of key/tag entries.
// A rejected insert or an empty remove gives its result beat straight from idle. An insert sifts up
// through read-parent and compare states to the root or under a smaller parent; a remove loads the root
// and last entry, then sifts down through read-children and compare states to a leaf or over a larger child.
// One item at a time: start is taken again in the result beat's cycle; the receiver cannot stall.
// Reset (rst, synchronous): count 0, capacity 64; heap memory is not cleared.
`default_nettype none

module binary_min_heap_queue_core #(
  parameter int DEPTH = bmhq_pkg::DEPTH_DEF,
  parameter int KEY_W = bmhq_pkg::KEY_W_DEF,
  parameter int TAG_W = bmhq_pkg::TAG_W_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       opcode,
  input  wire logic [KEY_W-1:0]           key,
  input  wire logic [TAG_W-1:0]           tag,
  input  wire logic                       cfg_we,
  input  wire logic [bmhq_pkg::CAP_W-1:0] cfg_wdata,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [KEY_W-1:0]                out_key,
  output logic [TAG_W-1:0]                out_tag,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  bmhq_pkg::cmd_t  cmd;
  bmhq_pkg::stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  bmhq_dp #(
    .DEPTH (DEPTH),
    .KEY_W (KEY_W),
    .TAG_W (TAG_W)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .tag       (tag),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .status    (status),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .count     (count)
  );

endmodule

`default_nettype wire

// ----- tb/sv/binary_min_heap_queue_core_tb.sv -----
// Self-checking testbench for binary_min_heap_queue_core: drives insert/remove
// commands and capacity writes, and checks each result beat against a heap mirror.
// Depends on bmhq_pkg and the binary_min_heap_queue_core RTL.
`default_nettype none

module binary_min_heap_queue_core_tb;

  localparam int HEAP_DEPTH = bmhq_pkg::DEPTH_DEF;
  localparam int KEY_BITS   = bmhq_pkg::KEY_W_DEF;
  localparam int TAG_BITS   = bmhq_pkg::TAG_W_DEF;
  localparam int CNT_BITS   = $clog2(HEAP_DEPTH + 1);

  typedef struct packed {
    bmhq_pkg::status_t     status;
    logic [KEY_BITS-1:0]   key;
    logic [TAG_BITS-1:0]   tag;
    logic [CNT_BITS-1:0]   count;
  } heap_result_t;

  // Mirror of the heap contents; predicts the result beat of every command.
  class min_heap_mirror;
    logic [KEY_BITS-1:0]        heap_key [HEAP_DEPTH];
    logic [TAG_BITS-1:0]        heap_tag [HEAP_DEPTH];
    int unsigned                held;
    logic [bmhq_pkg::CAP_W-1:0] capacity;
    heap_result_t               pending_results [$];
    int                         mismatches;

    function new();
      held       = 0;
      capacity   = bmhq_pkg::CAP_RESET;
      mismatches = 0;
    endfunction

    function void take_command(logic op, logic [KEY_BITS-1:0] k, logic [TAG_BITS-1:0] t);
      heap_result_t        r;
      int unsigned         place;
      int unsigned         parent;
      int unsigned         child;
      int unsigned         limit;
      logic [KEY_BITS-1:0] mk;
      logic [TAG_BITS-1:0] mt;
      r.status = bmhq_pkg::ST_OK;
      r.key    = '0;
      r.tag    = '0;
      if (op == bmhq_pkg::OP_INSERT) begin
        limit = (capacity > HEAP_DEPTH) ? HEAP_DEPTH : capacity;
        if (held >= limit) begin
          r.status = bmhq_pkg::ST_FULL;
        end else begin
          place = held;
          held++;
          // equal keys keep rising; stop only under a strictly smaller parent
          while (place > 0) begin
            parent = (place - 1) / 2;
            if (heap_key[parent] < k) break;
            heap_key[place] = heap_key[parent];
            heap_tag[place] = heap_tag[parent];
            place = parent;
          end
          heap_key[place] = k;
          heap_tag[place] = t;
        end
      end else if (held == 0) begin
        r.status = bmhq_pkg::ST_EMPTY;
      end else begin
        r.key = heap_key[0];
        r.tag = heap_tag[0];
        held--;
        mk    = heap_key[held];
        mt    = heap_tag[held];
        place = 0;
        while (1) begin
          child = 2 * place + 1;
          if (child >= held) break;
          // prefer the right child on a tie, only when it is in use
          if (child + 1 < held && heap_key[child + 1] <= heap_key[child]) child++;
          if (heap_key[child] > mk) break;
          heap_key[place] = heap_key[child];
          heap_tag[place] = heap_tag[child];
          place = child;
        end
        heap_key[place] = mk;
        heap_tag[place] = mt;
      end
      r.count = held[CNT_BITS-1:0];
      pending_results.push_back(r);
    endfunction

    function void compare_field(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(logic [1:0] st, logic [KEY_BITS-1:0] k,
                               logic [TAG_BITS-1:0] t, logic [CNT_BITS-1:0] c);
      heap_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %s %0h %0h %0h %0h",
                 $time, "status/key/tag/count", st, k, t, c);
        mismatches++;
        return;
      end
      e = pending_results.pop_front();
      compare_field("status", 64'(e.status), 64'(st));
      compare_field("out_key", 64'(e.key), 64'(k));
      compare_field("out_tag", 64'(e.tag), 64'(t));
      compare_field("count", 64'(e.count), 64'(c));
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic                       busy;
  logic                       opcode;
  logic [KEY_BITS-1:0]        key;
  logic [TAG_BITS-1:0]        tag;
  logic                       cfg_we;
  logic [bmhq_pkg::CAP_W-1:0] cfg_wdata;
  logic                       done;
  logic [1:0]                 status;
  logic [KEY_BITS-1:0]        out_key;
  logic [TAG_BITS-1:0]        out_tag;
  logic [CNT_BITS-1:0]        count;

  min_heap_mirror mirror;
  int             burst_left;

  binary_min_heap_queue_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .key       (key),
    .tag       (tag),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .done      (done),
    .status    (status),
    .out_key   (out_key),
    .out_tag   (out_tag),
    .count     (count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check the result beat before noting a command accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) mirror.match_result(status, out_key, out_tag, count);
      if (start && !busy) mirror.take_command(opcode, key, tag);
    end
  end

  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return KEY_BITS'($urandom_range(0, 15));
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  // Leaves start high when the burst goes on, so back-to-back beats need no dip.
  task automatic send_item(logic op, logic [KEY_BITS-1:0] k, logic [TAG_BITS-1:0] t);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
    start  <= 1'b1;
    opcode <= op;
    key    <= k;
    tag    <= t;
    do @(posedge clk); while (busy);
    burst_left--;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (mirror.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(logic [bmhq_pkg::CAP_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    mirror.capacity = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int n_items, int insert_pct);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(1, 100) <= insert_pct)
        send_item(bmhq_pkg::OP_INSERT, pick_key(), TAG_BITS'($urandom));
      else
        send_item(bmhq_pkg::OP_REMOVE, KEY_BITS'($urandom), TAG_BITS'($urandom));
    end
  endtask

  initial begin
    mirror     = new();
    burst_left = 0;
    rst       <= 1'b1;
    start     <= 1'b0;
    opcode    <= bmhq_pkg::OP_INSERT;
    key       <= '0;
    tag       <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty heap, extremes, ties, drain past empty at the reset capacity
    send_item(bmhq_pkg::OP_REMOVE, '1, '1);
    send_item(bmhq_pkg::OP_INSERT, '1, '1);
    send_item(bmhq_pkg::OP_INSERT, '0, '0);
    send_item(bmhq_pkg::OP_INSERT, KEY_BITS'(5), TAG_BITS'(1));
    send_item(bmhq_pkg::OP_INSERT, KEY_BITS'(5), TAG_BITS'(2));
    send_item(bmhq_pkg::OP_INSERT, KEY_BITS'(5), TAG_BITS'(3));
    repeat (6) send_item(bmhq_pkg::OP_REMOVE, '0, '0);

    // zero capacity rejects every insert
    write_capacity(7'd0);
    send_item(bmhq_pkg::OP_INSERT, KEY_BITS'(9), TAG_BITS'(9));
    send_item(bmhq_pkg::OP_REMOVE, '0, '0);

    // fill to a small capacity, then lower it below the count
    write_capacity(7'd2);
    send_item(bmhq_pkg::OP_INSERT, KEY_BITS'(7), TAG_BITS'(16'h00aa));
    send_item(bmhq_pkg::OP_INSERT, KEY_BITS'(3), TAG_BITS'(16'h5500));
    send_item(bmhq_pkg::OP_INSERT, KEY_BITS'(1), TAG_BITS'(16'hffff));
    write_capacity(7'd1);
    send_item(bmhq_pkg::OP_INSERT, KEY_BITS'(2), TAG_BITS'(1));
    send_item(bmhq_pkg::OP_REMOVE, '0, '0);
    send_item(bmhq_pkg::OP_INSERT, KEY_BITS'(2), TAG_BITS'(1));
    send_item(bmhq_pkg::OP_REMOVE, '0, '0);
    send_item(bmhq_pkg::OP_INSERT, KEY_BITS'(4), TAG_BITS'(2));
    send_item(bmhq_pkg::OP_REMOVE, '0, '0);

    // capacity above depth acts as depth: overfill, then overdrain
    write_capacity(7'd127);
    repeat (72) send_item(bmhq_pkg::OP_INSERT, pick_key(), TAG_BITS'($urandom));
    repeat (72) send_item(bmhq_pkg::OP_REMOVE, KEY_BITS'($urandom), TAG_BITS'($urandom));

    write_capacity(7'd64);
    run_phase(70, 65);
    write_capacity(7'd7);
    run_phase(70, 55);
    write_capacity(7'd1);
    run_phase(50, 50);
    write_capacity(7'd0);
    run_phase(16, 50);
    write_capacity(7'd40);
    run_phase(60, 80);
    write_capacity(7'd4);
    run_phase(60, 50);
    write_capacity(7'd64);
    run_phase(80, 30);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending_results.size() == 0)
      $display("binary_min_heap_queue_core_tb: clean");
    else
      $display("binary_min_heap_queue_core_tb: errors");
    $finish;
  end

  initial begin
    #3000000;
    $display("binary_min_heap_queue_core_tb: errors");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/bmhq_pkg.sv
rtl/bmhq_ctrl.sv
rtl/bmhq_dp.sv
rtl/binary_min_heap_queue_core.sv
tb/sv/binary_min_heap_queue_core_tb.sv
